// File: hdl/card_number_luhn_check_macros.svh
// Assertion helpers for the card number check.
// Each one samples on the rising edge of clock and is off while reset is high.
`ifndef CARD_NUMBER_LUHN_CHECK_MACROS_SVH
`define CARD_NUMBER_LUHN_CHECK_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define CNLC_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("card number check: same-cycle property failed");

// The consequent holds in the cycle after the antecedent.
`define CNLC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("card number check: next-cycle property failed");

`endif

// File: hdl/cnlc_pkg.sv
package cnlc_pkg;

   // Input and BCD geometry
   localparam int CARD_W        = 64;
   localparam int DIGIT_W       = 4;
   localparam int NUM_DIGITS    = 20;
   localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = CARD_W / BITS_PER_STEP;
   localparam int PAIR_STEPS    = NUM_DIGITS / 2;
   localparam int STEP_CNT_W    = 4;

   // Result field widths
   localparam int COUNT_W  = 5;
   localparam int PREFIX_W = 7;
   localparam int REM_W    = 4;
   localparam int BRAND_W  = 2;

   // Brand rules
   localparam int MAX_DIGITS     = 19;
   localparam int AMEX_DIGITS    = 15;
   localparam int SHORT_DIGITS   = 13;
   localparam int LONG_DIGITS    = 16;
   localparam int AMEX_PREFIX_A  = 34;
   localparam int AMEX_PREFIX_B  = 37;
   localparam int MC_PREFIX_LOW  = 50;
   localparam int MC_PREFIX_HIGH = 56;
   localparam int VISA_PREFIX    = 4;

   // Brand codes
   localparam logic [BRAND_W-1:0] BRAND_INVALID    = 2'd0;
   localparam logic [BRAND_W-1:0] BRAND_AMEX       = 2'd1;
   localparam logic [BRAND_W-1:0] BRAND_MASTERCARD = 2'd2;
   localparam logic [BRAND_W-1:0] BRAND_VISA       = 2'd3;

   typedef logic [DIGIT_W-1:0]  digit_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [PREFIX_W-1:0] prefix_type;
   typedef logic [REM_W-1:0]    rem_type;

   // Sequencer commands to the datapath
   typedef struct packed {
      logic load;    // take a new number, clear the scan
      logic conv;    // one double-dabble step
      logic shift;   // move one digit pair into the scan
   } ctl_type;

endpackage

// File: hdl/card_number_luhn_check.sv
// Card number check: each transfer on the req_ channel carries one unsigned
// binary card number; one result follows on the rsp_ channel with the decimal
// digit count, the leading prefix, the Luhn remainder (zero passes) and the
// brand code. From transfer to registered result a number passes through a
// load step, double-dabble steps that convert four bits each, a scan of the
// twenty BCD digits two at a time, and a step that classifies the brand and
// fills the output register. The double-dabble converter and the digit
// scanner serve one number at a time, so req_stall stays high from a transfer
// until that number's result has entered the output register; the next number
// is taken while that result still waits.
module card_number_luhn_check (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cnlc_pkg::CARD_W-1:0]       req_card_number,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cnlc_pkg::COUNT_W-1:0]      rsp_digit_count,
   output logic [cnlc_pkg::PREFIX_W-1:0]     rsp_leading_prefix,
   output logic [cnlc_pkg::REM_W-1:0]        rsp_luhn_remainder,
   output logic [cnlc_pkg::BRAND_W-1:0]      rsp_brand_code
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [cnlc_pkg::STEP_CNT_W-1:0] cnt_ff, cnt_in;
   cnlc_pkg::ctl_type               ctl;
   cnlc_pkg::digit_type             digit_lo, digit_hi;
   cnlc_pkg::count_type             scan_count;
   cnlc_pkg::prefix_type            scan_prefix;
   cnlc_pkg::rem_type               scan_rem;
   logic [cnlc_pkg::BRAND_W-1:0]    brand;
   logic                            out_load;
   logic                            rsp_valid_ff, rsp_valid_in;
   cnlc_pkg::count_type             count_ff;
   cnlc_pkg::prefix_type            prefix_ff;
   cnlc_pkg::rem_type               rem_ff;
   logic [cnlc_pkg::BRAND_W-1:0]    brand_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ctl.load  = 1'b0;
      ctl.conv  = 1'b0;
      ctl.shift = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            ctl.conv = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == cnlc_pkg::STEP_CNT_W'(cnlc_pkg::CONV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctl.shift = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == cnlc_pkg::STEP_CNT_W'(cnlc_pkg::PAIR_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   cnlc_bcd u_bcd (
      .clock       (clock),
      .ctl         (ctl),
      .card_number (req_card_number),
      .digit_lo    (digit_lo),
      .digit_hi    (digit_hi)
   );

   cnlc_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .digit_lo       (digit_lo),
      .digit_hi       (digit_hi),
      .digit_count    (scan_count),
      .leading_prefix (scan_prefix),
      .luhn_remainder (scan_rem)
   );

   // Classify the brand; only a passing checksum within the length limit counts
   always_comb begin
      brand = cnlc_pkg::BRAND_INVALID;
      if (scan_rem == '0 && scan_count <= cnlc_pkg::COUNT_W'(cnlc_pkg::MAX_DIGITS)) begin
         if (scan_count == cnlc_pkg::COUNT_W'(cnlc_pkg::AMEX_DIGITS)) begin
            if (scan_prefix == cnlc_pkg::PREFIX_W'(cnlc_pkg::AMEX_PREFIX_A) ||
                scan_prefix == cnlc_pkg::PREFIX_W'(cnlc_pkg::AMEX_PREFIX_B)) begin
               brand = cnlc_pkg::BRAND_AMEX;
            end
         end else if (scan_count == cnlc_pkg::COUNT_W'(cnlc_pkg::SHORT_DIGITS) ||
                      scan_count == cnlc_pkg::COUNT_W'(cnlc_pkg::LONG_DIGITS)) begin
            if (scan_prefix > cnlc_pkg::PREFIX_W'(cnlc_pkg::MC_PREFIX_LOW) &&
                scan_prefix < cnlc_pkg::PREFIX_W'(cnlc_pkg::MC_PREFIX_HIGH)) begin
               brand = cnlc_pkg::BRAND_MASTERCARD;
            end else if (scan_prefix == cnlc_pkg::PREFIX_W'(cnlc_pkg::VISA_PREFIX)) begin
               brand = cnlc_pkg::BRAND_VISA;
            end
         end
      end
   end

   // Output register: fill on load, drop after the transfer, hold while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         count_ff  <= scan_count;
         prefix_ff <= scan_prefix;
         rem_ff    <= scan_rem;
         brand_ff  <= brand;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_digit_count    = count_ff;
   assign rsp_leading_prefix = prefix_ff;
   assign rsp_luhn_remainder = rem_ff;
   assign rsp_brand_code     = brand_ff;

endmodule

// File: hdl/cnlc_bcd.sv
// Binary to BCD converter (double dabble, several bits per cycle) that then
// shifts its digits out from the low end, two per cycle.
module cnlc_bcd (
   input  logic                             clock,
   input  cnlc_pkg::ctl_type                ctl,
   input  logic [cnlc_pkg::CARD_W-1:0]      card_number,
   output cnlc_pkg::digit_type              digit_lo,
   output cnlc_pkg::digit_type              digit_hi
);

   logic [cnlc_pkg::CARD_W-1:0] bin_ff, bin_in;
   logic [cnlc_pkg::BCD_W-1:0]  bcd_ff, bcd_in;
   logic [cnlc_pkg::CARD_W-1:0] step_bin;
   logic [cnlc_pkg::BCD_W-1:0]  step_bcd;

   // Run the add-3 and shift sequence for one group of input bits
   always_comb begin
      step_bin = bin_ff;
      step_bcd = bcd_ff;
      for (int s = 0; s < cnlc_pkg::BITS_PER_STEP; s++) begin
         for (int n = 0; n < cnlc_pkg::NUM_DIGITS; n++) begin
            if (step_bcd[n*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] >= 4'd5) begin
               step_bcd[n*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] =
                  step_bcd[n*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] + 4'd3;
            end
         end
         step_bcd = {step_bcd[cnlc_pkg::BCD_W-2:0], step_bin[cnlc_pkg::CARD_W-1]};
         step_bin = {step_bin[cnlc_pkg::CARD_W-2:0], 1'b0};
      end
   end

   // Load, convert, or drop the low digit pair
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctl.load) begin
         bin_in = card_number;
         bcd_in = '0;
      end else if (ctl.conv) begin
         bin_in = step_bin;
         bcd_in = step_bcd;
      end else if (ctl.shift) begin
         bcd_in = {{(2*cnlc_pkg::DIGIT_W){1'b0}},
                   bcd_ff[cnlc_pkg::BCD_W-1:2*cnlc_pkg::DIGIT_W]};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign digit_lo = bcd_ff[cnlc_pkg::DIGIT_W-1:0];
   assign digit_hi = bcd_ff[2*cnlc_pkg::DIGIT_W-1:cnlc_pkg::DIGIT_W];

endmodule

// File: hdl/cnlc_scan.sv
// Digit pair scanner: running Luhn remainder, digit count and leading digits.
// The low digit of each pair sits at an even position from the right, the
// high digit at an odd one and is doubled.
module cnlc_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  cnlc_pkg::ctl_type     ctl,
   input  cnlc_pkg::digit_type   digit_lo,
   input  cnlc_pkg::digit_type   digit_hi,
   output cnlc_pkg::count_type   digit_count,
   output cnlc_pkg::prefix_type  leading_prefix,
   output cnlc_pkg::rem_type     luhn_remainder
);

   logic [cnlc_pkg::STEP_CNT_W-1:0] pos_ff, pos_in;
   cnlc_pkg::count_type             count_ff, count_in;
   cnlc_pkg::digit_type             top_ff, top_in;
   cnlc_pkg::digit_type             below_ff, below_in;
   cnlc_pkg::digit_type             prev_hi_ff, prev_hi_in;
   cnlc_pkg::rem_type               rem_ff, rem_in;
   cnlc_pkg::digit_type             hi_dbl;
   logic [4:0]                      pair_sum;
   cnlc_pkg::count_type             base;
   logic [cnlc_pkg::PREFIX_W-1:0]   top_x10;

   // Double the odd-position digit, folding two-digit results
   always_comb begin
      if (digit_hi >= 4'd5) begin
         hi_dbl = cnlc_pkg::digit_type'({digit_hi, 1'b0} - 5'd9);
      end else begin
         hi_dbl = cnlc_pkg::digit_type'({digit_hi, 1'b0});
      end
   end

   assign pair_sum = 5'(rem_ff) + 5'(digit_lo) + 5'(hi_dbl);
   assign base     = cnlc_pkg::count_type'({pos_ff, 1'b0});

   always_comb begin
      pos_in     = pos_ff;
      count_in   = count_ff;
      top_in     = top_ff;
      below_in   = below_ff;
      prev_hi_in = prev_hi_ff;
      rem_in     = rem_ff;
      if (ctl.load) begin
         pos_in     = '0;
         count_in   = 5'd1;
         top_in     = '0;
         below_in   = '0;
         prev_hi_in = '0;
         rem_in     = '0;
      end else if (ctl.shift) begin
         pos_in     = pos_ff + 1'b1;
         prev_hi_in = digit_hi;
         // Fold the running sum back below ten
         if (pair_sum >= 5'd20) begin
            rem_in = cnlc_pkg::rem_type'(pair_sum - 5'd20);
         end else if (pair_sum >= 5'd10) begin
            rem_in = cnlc_pkg::rem_type'(pair_sum - 5'd10);
         end else begin
            rem_in = cnlc_pkg::rem_type'(pair_sum);
         end
         // Track the highest nonzero digit and the one under it
         if (digit_hi != '0) begin
            count_in = base + 5'd2;
            top_in   = digit_hi;
            below_in = digit_lo;
         end else if (digit_lo != '0) begin
            count_in = base + 5'd1;
            top_in   = digit_lo;
            below_in = prev_hi_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
      count_ff   <= count_in;
      top_ff     <= top_in;
      below_ff   <= below_in;
      prev_hi_ff <= prev_hi_in;
      rem_ff     <= rem_in;
   end

   // Two-digit prefix for leading 3 or 5 when a second digit exists
   assign top_x10 = cnlc_pkg::prefix_type'({top_ff, 3'b000}) +
                    cnlc_pkg::prefix_type'({top_ff, 1'b0});

   always_comb begin
      if ((top_ff == 4'd3 || top_ff == 4'd5) && count_ff >= 5'd2) begin
         leading_prefix = top_x10 + cnlc_pkg::prefix_type'(below_ff);
      end else begin
         leading_prefix = cnlc_pkg::prefix_type'(top_ff);
      end
   end

   assign digit_count    = count_ff;
   assign luhn_remainder = rem_ff;

endmodule

// File: hdl/cnlc_checker.sv
`include "card_number_luhn_check_macros.svh"

module cnlc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [cnlc_pkg::CARD_W-1:0]       req_card_number,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [cnlc_pkg::COUNT_W-1:0]      rsp_digit_count,
   input logic [cnlc_pkg::PREFIX_W-1:0]     rsp_leading_prefix,
   input logic [cnlc_pkg::REM_W-1:0]        rsp_luhn_remainder,
   input logic [cnlc_pkg::BRAND_W-1:0]      rsp_brand_code
);

   // A stalled request holds its number
   `CNLC_ASSERT_NEXT(a_req_hold, req_valid && req_stall,
      req_valid && $stable(req_card_number))

   // A stalled result holds
   `CNLC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_digit_count) && $stable(rsp_leading_prefix) &&
      $stable(rsp_luhn_remainder) && $stable(rsp_brand_code))

   // A new number is not taken while one is in work
   `CNLC_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall)

   // Digit count and remainder stay in range
   `CNLC_ASSERT_SAME(a_ranges, rsp_valid,
      rsp_digit_count != 5'd0 && rsp_digit_count <= 5'd20 && rsp_luhn_remainder <= 4'd9)

   // A brand is given only for a passing checksum
   `CNLC_ASSERT_SAME(a_brand_pass, rsp_valid && rsp_brand_code != cnlc_pkg::BRAND_INVALID,
      rsp_luhn_remainder == 4'd0)

endmodule

bind card_number_luhn_check cnlc_checker u_checker (.*);
